FILE: hdl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// Box blur package
// Shared constants, widths and types of the 3x3 box blur core.
// ----------------------------------------------------------------------------
`default_nettype none

package bb3_pkg;

	// Widest frame that the line stores hold.
	localparam int MAX_WIDTH = 1024;

	// Column index, effective width and pending count widths.
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WEFF_W = COL_W + 1;
	localparam int PEND_W = WEFF_W + 1;

	// Row counter and configuration register widths.
	localparam int ROW_W      = 16;
	localparam int CFG_WID_W  = 11;
	localparam int CFG_HGT_W  = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	// Reset values of the configuration registers.
	localparam logic [CFG_WID_W-1:0] WIDTH_RESET  = CFG_WID_W'(640);
	localparam logic [CFG_HGT_W-1:0] HEIGHT_RESET = CFG_HGT_W'(480);

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// Request kinds.
	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;

	// Colour channels within a pixel word (red is the top byte).
	localparam int CH_N     = 3;
	localparam int CH_RED   = 2;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 0;

	// Window geometry: three columns of three rows, column major.
	localparam int WIN_N = 9;
	localparam int WIN_R = 3;

	// Reciprocal for an exact division by three of values below 2^16.
	localparam logic [15:0] DIV3_MUL = 16'hAAAB;
	localparam int          DIV3_SH  = 17;

	typedef logic [CH_N-1:0][7:0] pix_t;

	// Which neighbours fall outside the frame for the pixel being output.
	typedef struct packed {
		logic top_miss;
		logic bot_miss;
		logic left_miss;
		logic right_miss;
	} edge_t;

	// Position in the frame.
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} pos_t;

endpackage

`default_nettype wire

FILE: hdl/bb3_stream_if.sv
// ----------------------------------------------------------------------------
// Box blur stream interfaces
// Valid/ready channels for incoming pixels and outgoing blurred pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface bb3_pix_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;

	modport source (output valid, mode, red_in, green_in, blue_in, input ready);
	modport sink (input valid, mode, red_in, green_in, blue_in, output ready);
endinterface

interface bb3_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       frame_end;

	modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
	modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

`default_nettype wire

FILE: hdl/bb3_avg.sv
// ----------------------------------------------------------------------------
// Box blur averaging unit
// Four-stage pipeline that sums the in-frame pixels of the window and divides
// by their count, rounding half away from zero.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_avg (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire bb3_pkg::pix_t [bb3_pkg::WIN_N-1:0] win,
	input  wire bb3_pkg::edge_t              edges,
	output logic                             done,
	output bb3_pkg::pix_t                    avg
);

	logic                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic [9:0]           csum_s1 [bb3_pkg::CH_N][bb3_pkg::WIN_R];
	bb3_pkg::edge_t       edges_s1;
	logic [11:0]          y_s2 [bb3_pkg::CH_N];
	logic                 div3_s2, div9_s2, div9_s3;
	logic [11:0]          q_s3 [bb3_pkg::CH_N];
	bb3_pkg::pix_t        avg_s4;

	logic [9:0]           csum_c [bb3_pkg::CH_N][bb3_pkg::WIN_R];
	logic [11:0]          y_c [bb3_pkg::CH_N];
	logic [11:0]          q_c [bb3_pkg::CH_N];
	bb3_pkg::pix_t        avg_c;
	logic                 div3_c, div9_c;
	logic [1:0]           rows_c, cols_c;
	logic [3:0]           n_c;

	// Exact floor division by three through the reciprocal.
	function automatic logic [11:0] div3(input logic [11:0] v);
		logic [27:0] prod;
		prod = 28'(v) * 28'(bb3_pkg::DIV3_MUL);
		return 12'(prod >> bb3_pkg::DIV3_SH);
	endfunction

	// Stage 1: per column sums of the rows that lie inside the frame.
	always_comb begin
		for (int ch = 0; ch < bb3_pkg::CH_N; ch++) begin
			for (int c = 0; c < bb3_pkg::WIN_R; c++) begin
				csum_c[ch][c] = (edges.top_miss ? 10'd0 : 10'(win[c*bb3_pkg::WIN_R][ch]))
					+ 10'(win[c*bb3_pkg::WIN_R+1][ch])
					+ (edges.bot_miss ? 10'd0 : 10'(win[c*bb3_pkg::WIN_R+2][ch]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			csum_s1  <= csum_c;
			edges_s1 <= edges;
		end
	end

	// Stage 2: window total, rounding term and the power-of-two part of 2n.
	always_comb begin
		rows_c = 2'd3 - 2'(edges_s1.top_miss) - 2'(edges_s1.bot_miss);
		cols_c = 2'd3 - 2'(edges_s1.left_miss) - 2'(edges_s1.right_miss);
		n_c    = 4'(rows_c) * 4'(cols_c);
		div3_c = 1'b0;
		div9_c = 1'b0;
		for (int ch = 0; ch < bb3_pkg::CH_N; ch++) begin
			logic [11:0] total;
			logic [12:0] x;
			total = (edges_s1.left_miss ? 12'd0 : 12'(csum_s1[ch][0]))
				+ 12'(csum_s1[ch][1])
				+ (edges_s1.right_miss ? 12'd0 : 12'(csum_s1[ch][2]));
			x = {total, 1'b0} + 13'(n_c);
			case (n_c)
				4'd1:    y_c[ch] = 12'(x >> 1);
				4'd2:    y_c[ch] = 12'(x >> 2);
				4'd3:    y_c[ch] = 12'(x >> 1);
				4'd4:    y_c[ch] = 12'(x >> 3);
				4'd6:    y_c[ch] = 12'(x >> 2);
				default: y_c[ch] = 12'(x >> 1);
			endcase
		end
		case (n_c)
			4'd3:    div3_c = 1'b1;
			4'd6:    div3_c = 1'b1;
			4'd9:    begin
				div3_c = 1'b1;
				div9_c = 1'b1;
			end
			default: div3_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			y_s2    <= y_c;
			div3_s2 <= div3_c;
			div9_s2 <= div9_c;
		end
	end

	// Stage 3: first division by three where the count calls for it.
	always_comb begin
		for (int ch = 0; ch < bb3_pkg::CH_N; ch++) begin
			q_c[ch] = div3_s2 ? div3(y_s2[ch]) : y_s2[ch];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			q_s3    <= q_c;
			div9_s3 <= div9_s2;
		end
	end

	// Stage 4: second division by three for a full window, then the clamp.
	always_comb begin
		for (int ch = 0; ch < bb3_pkg::CH_N; ch++) begin
			logic [11:0] q;
			q = div9_s3 ? div3(q_s3[ch]) : q_s3[ch];
			avg_c[ch] = (q > 12'd255) ? 8'd255 : q[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			avg_s4 <= avg_c;
		end
	end

	// Stage valid chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	assign done = valid_s4;
	assign avg  = avg_s4;

	// A start never lands while an earlier average is still in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !(valid_s1 || valid_s2 || valid_s3))
		else $error("averaging unit restarted while busy");

	// Each start yields exactly one result, raised on done by the last stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ##3 done)
		else $error("average did not complete on time");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("average completed without a start");

endmodule

`default_nettype wire

FILE: hdl/box_blur_3x3_edge_average_core.sv
// ----------------------------------------------------------------------------
// 3x3 box blur core
// RGB pixels in raster order are blurred with a 3x3 box that averages only the
// neighbours inside the frame, using two line stores and a sliding window.
// ----------------------------------------------------------------------------
// Each request carries one pixel or a drain marker. Results lag the input by
// one row plus one pixel; drain requests push out the results still pending at
// the end of a frame. The core works on one request at a time: a request that
// yields no result goes through a line store read, then write back and window
// shift; one that yields a result also passes through the four-stage averaging
// pipeline and the hand-over to the output register. The output register lets
// the next request be taken while a result waits downstream; a new result that
// finds the output register still occupied holds the core until that register
// is emptied. Width and height are written through the configuration port; the
// user must write them only while the core is idle, which the core itself does
// not enforce. The line stores need no clearing after reset.
`default_nettype none

module box_blur_3x3_edge_average_core (
	input  wire                                  clk,
	input  wire                                  arst_n,
	bb3_pix_if.sink                              pixel,
	bb3_res_if.source                            result,
	input  wire                                  cfg_we,
	input  wire [bb3_pkg::CFG_IDX_W-1:0]         cfg_idx,
	input  wire [bb3_pkg::CFG_DATA_W-1:0]        cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MEM  = 4'b0010,
		ST_AVG  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t                            state_q;
	logic [bb3_pkg::CFG_WID_W-1:0]     width_q;
	logic [bb3_pkg::CFG_HGT_W-1:0]     height_q;
	bb3_pkg::pos_t                     in_pos_q, out_pos_q;
	logic [bb3_pkg::PEND_W-1:0]        pend_q;
	logic                              emit_q;
	logic                              frame_end_q;
	bb3_pkg::edge_t                    edges_q;
	logic                              start_q;
	logic [bb3_pkg::COL_W-1:0]         idx_q;
	bb3_pkg::pix_t                     pix_q;
	bb3_pkg::pix_t                     up_rd_q, mid_rd_q;
	bb3_pkg::pix_t [bb3_pkg::WIN_N-1:0] win_q;
	logic                              out_valid_q;
	bb3_pkg::pix_t                     out_pix_q;
	logic                              out_end_q;

	bb3_pkg::pix_t                     upper_mem [bb3_pkg::MAX_WIDTH];
	bb3_pkg::pix_t                     middle_mem [bb3_pkg::MAX_WIDTH];

	logic [bb3_pkg::WEFF_W-1:0]        w_eff;
	logic [bb3_pkg::CFG_HGT_W-1:0]     h_eff;
	logic                              accept, is_drain, work, emit;
	logic                              out_free;
	bb3_pkg::pos_t                     in_adv, out_adv;
	bb3_pkg::edge_t                    edges_c;
	logic [bb3_pkg::PEND_W-1:0]        pend_nxt;
	logic                              avg_done;
	bb3_pkg::pix_t                     avg_pix;

	// Step a position one pixel on, wrapping at the row and frame ends.
	function automatic bb3_pkg::pos_t advance(
		input bb3_pkg::pos_t p,
		input logic [bb3_pkg::WEFF_W-1:0] w,
		input logic [bb3_pkg::CFG_HGT_W-1:0] h
	);
		bb3_pkg::pos_t           n;
		logic [bb3_pkg::WEFF_W-1:0] col_inc;
		logic [bb3_pkg::ROW_W:0]    row_inc;
		col_inc = {1'b0, p.col} + bb3_pkg::WEFF_W'(1);
		row_inc = {1'b0, p.row} + (bb3_pkg::ROW_W+1)'(1);
		n = p;
		if (col_inc >= w) begin
			n.col = '0;
			n.row = (row_inc >= {1'b0, h}) ? '0 : row_inc[bb3_pkg::ROW_W-1:0];
		end else begin
			n.col = col_inc[bb3_pkg::COL_W-1:0];
		end
		return n;
	endfunction

	// Effective frame size: zero reads as one, width capped at the store size.
	always_comb begin
		if (width_q == '0) begin
			w_eff = bb3_pkg::WEFF_W'(1);
		end else if (32'(width_q) > 32'(bb3_pkg::MAX_WIDTH)) begin
			w_eff = bb3_pkg::WEFF_W'(bb3_pkg::MAX_WIDTH);
		end else begin
			w_eff = bb3_pkg::WEFF_W'(width_q);
		end
		h_eff = (height_q == '0) ? bb3_pkg::CFG_HGT_W'(1) : height_q;
	end

	// Request decode: what this request does to the counters.
	always_comb begin
		accept   = pixel.valid && pixel.ready;
		is_drain = (pixel.mode == bb3_pkg::MODE_DRAIN);
		work     = !is_drain || (pend_q != '0);
		if (is_drain) begin
			emit     = (pend_q != '0);
			pend_nxt = pend_q - bb3_pkg::PEND_W'(1);
		end else begin
			emit     = (pend_q > bb3_pkg::PEND_W'(w_eff));
			pend_nxt = emit ? pend_q : pend_q + bb3_pkg::PEND_W'(1);
		end
		in_adv  = advance(in_pos_q, w_eff, h_eff);
		out_adv = advance(out_pos_q, w_eff, h_eff);
		edges_c.top_miss   = (out_pos_q.row == '0);
		edges_c.bot_miss   = (({1'b0, out_pos_q.row} + (bb3_pkg::ROW_W+1)'(1))
			>= {1'b0, h_eff});
		edges_c.left_miss  = (out_pos_q.col == '0);
		edges_c.right_miss = (({1'b0, out_pos_q.col} + bb3_pkg::WEFF_W'(1)) >= w_eff);
	end

	assign pixel.ready = (state_q == ST_IDLE);
	assign out_free    = !out_valid_q || result.ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bb3_pkg::WIDTH_RESET;
			height_q <= bb3_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				bb3_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[bb3_pkg::CFG_WID_W-1:0];
				bb3_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data[bb3_pkg::CFG_HGT_W-1:0];
				default:                   width_q  <= width_q;
			endcase
		end
	end

	// Sequencer and position counters; counters move when a request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			in_pos_q  <= '0;
			out_pos_q <= '0;
			pend_q    <= '0;
			emit_q    <= 1'b0;
			start_q   <= 1'b0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && work) begin
						state_q <= ST_MEM;
						emit_q  <= emit;
						pend_q  <= pend_nxt;
						if (emit) begin
							out_pos_q <= out_adv;
						end
						// A drain that empties the pipeline realigns the input.
						if (is_drain && pend_nxt == '0) begin
							in_pos_q <= out_adv;
						end else begin
							in_pos_q <= in_adv;
						end
					end
				end
				ST_MEM: begin
					if (emit_q) begin
						state_q <= ST_AVG;
						start_q <= 1'b1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_AVG: begin
					if (avg_done) begin
						state_q <= out_free ? ST_IDLE : ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request payload and output geometry, captured when a request is taken.
	always_ff @(posedge clk) begin
		if (accept && work) begin
			idx_q       <= in_pos_q.col;
			pix_q       <= is_drain ? '0 : {pixel.red_in, pixel.green_in, pixel.blue_in};
			edges_q     <= edges_c;
			frame_end_q <= edges_c.right_miss && edges_c.bot_miss;
		end
	end

	// Upper line store: read on accept, written back with the middle row.
	always_ff @(posedge clk) begin
		if (accept && work) begin
			up_rd_q <= upper_mem[in_pos_q.col];
		end
		if (state_q == ST_MEM) begin
			upper_mem[idx_q] <= mid_rd_q;
		end
	end

	// Middle line store: read on accept, written back with the new pixel.
	always_ff @(posedge clk) begin
		if (accept && work) begin
			mid_rd_q <= middle_mem[in_pos_q.col];
		end
		if (state_q == ST_MEM) begin
			middle_mem[idx_q] <= pix_q;
		end
	end

	// Window shifts one column left and takes the new column on the right.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (state_q == ST_MEM) begin
			for (int k = 0; k < bb3_pkg::WIN_N - bb3_pkg::WIN_R; k++) begin
				win_q[k] <= win_q[k + bb3_pkg::WIN_R];
			end
			win_q[bb3_pkg::WIN_N-3] <= up_rd_q;
			win_q[bb3_pkg::WIN_N-2] <= mid_rd_q;
			win_q[bb3_pkg::WIN_N-1] <= pix_q;
		end
	end

	bb3_avg u_avg (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.win    (win_q),
		.edges  (edges_q),
		.done   (avg_done),
		.avg    (avg_pix)
	);

	// Output register: loaded when the average is ready and the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_AVG && avg_done) || state_q == ST_OUT) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
			end
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (((state_q == ST_AVG && avg_done) || state_q == ST_OUT) && out_free) begin
			out_pix_q <= avg_pix;
			out_end_q <= frame_end_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.red_out   = out_pix_q[bb3_pkg::CH_RED];
	assign result.green_out = out_pix_q[bb3_pkg::CH_GREEN];
	assign result.blue_out  = out_pix_q[bb3_pkg::CH_BLUE];
	assign result.frame_end = out_end_q;

	// The averaging pipeline only finishes while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		avg_done |-> state_q == ST_AVG)
		else $error("average finished outside the wait state");

	// The pending count never exceeds the widest row (MAX_WIDTH) plus one pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(pend_q) <= 32'(bb3_pkg::MAX_WIDTH) + 32'd1)
		else $error("pending count out of range");

	// A drain with nothing pending leaves the core idle and untouched.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_drain && pend_q == '0) |=> state_q == ST_IDLE && pend_q == '0)
		else $error("empty drain changed state");

	// Every pixel request goes through the line store write-back.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_drain) |=> state_q == ST_MEM)
		else $error("pixel request skipped the line store update");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// 3x3 box blur core testbench
// Streams RGB pixels and drain requests into the core with random idling on
// both sides, predicts every blurred pixel in a scoreboard and compares the
// results in order as they leave the core.
// ----------------------------------------------------------------------------

module tb_top;

	// One blurred pixel as it leaves the core.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_end;
	} blurred_t;

	// Predicts the blurred pixels and checks them against the core's results.
	class blur_scoreboard;
		bb3_pkg::pix_t                 upper_line [bb3_pkg::MAX_WIDTH];
		bb3_pkg::pix_t                 middle_line [bb3_pkg::MAX_WIDTH];
		bb3_pkg::pix_t                 window [bb3_pkg::WIN_N];
		int unsigned                   in_row, in_col, out_row, out_col;
		int unsigned                   backlog;
		logic [bb3_pkg::CFG_WID_W-1:0] width_reg;
		logic [bb3_pkg::CFG_HGT_W-1:0] height_reg;
		blurred_t                      expected_pixels [$];
		int unsigned                   errors;

		// The line stores are left unknown, as they are in the core after reset.
		function new();
			for (int k = 0; k < bb3_pkg::WIN_N; k++) window[k] = '0;
			in_row = 0;
			in_col = 0;
			out_row = 0;
			out_col = 0;
			backlog = 0;
			width_reg = bb3_pkg::WIDTH_RESET;
			height_reg = bb3_pkg::HEIGHT_RESET;
			errors = 0;
		endfunction

		function void write_reg(logic [bb3_pkg::CFG_IDX_W-1:0] idx,
				logic [bb3_pkg::CFG_DATA_W-1:0] data);
			if (idx == bb3_pkg::REG_IMAGE_WIDTH)
				width_reg = data[bb3_pkg::CFG_WID_W-1:0];
			else
				height_reg = data[bb3_pkg::CFG_HGT_W-1:0];
		endfunction

		// Raster step; a position beyond the frame wraps as at the end of a row.
		function void step_pos(inout int unsigned row, inout int unsigned col,
				input int unsigned w, input int unsigned h);
			col++;
			if (col >= w) begin
				col = 0;
				row++;
				if (row >= h)
					row = 0;
			end
		endfunction

		// Reads the two rows above, moves the column into the window and the line stores.
		function void push_into_window(bb3_pkg::pix_t px, int unsigned w, int unsigned h);
			int unsigned   col;
			int            k;
			bb3_pkg::pix_t top_px;
			bb3_pkg::pix_t mid_px;
			col = (in_col < bb3_pkg::MAX_WIDTH) ? in_col : 0;
			top_px = upper_line[col];
			mid_px = middle_line[col];
			upper_line[col] = mid_px;
			middle_line[col] = px;
			for (k = 0; k < 2 * bb3_pkg::WIN_R; k++)
				window[k] = window[k + bb3_pkg::WIN_R];
			window[2 * bb3_pkg::WIN_R] = top_px;
			window[2 * bb3_pkg::WIN_R + 1] = mid_px;
			window[2 * bb3_pkg::WIN_R + 2] = px;
			step_pos(in_row, in_col, w, h);
		endfunction

		// Averages the in-frame neighbours of the next output position, rounding half up.
		function void blur_next_output(int unsigned w, int unsigned h);
			int unsigned r_lo, r_hi, c_lo, c_hi, n, c, r, ch;
			int unsigned total [bb3_pkg::CH_N];
			int unsigned avg [bb3_pkg::CH_N];
			blurred_t    res;
			r_lo = (out_row > 0) ? 0 : 1;
			r_hi = (out_row + 1 < h) ? 2 : 1;
			c_lo = (out_col > 0) ? 0 : 1;
			c_hi = (out_col + 1 < w) ? 2 : 1;
			n = (r_hi - r_lo + 1) * (c_hi - c_lo + 1);
			for (ch = 0; ch < bb3_pkg::CH_N; ch++)
				total[ch] = 0;
			for (c = c_lo; c <= c_hi; c++)
				for (r = r_lo; r <= r_hi; r++)
					for (ch = 0; ch < bb3_pkg::CH_N; ch++)
						total[ch] += window[c * bb3_pkg::WIN_R + r][ch];
			for (ch = 0; ch < bb3_pkg::CH_N; ch++) begin
				avg[ch] = (2 * total[ch] + n) / (2 * n);
				if (avg[ch] > 255)
					avg[ch] = 255;
			end
			res.red = avg[bb3_pkg::CH_RED][7:0];
			res.green = avg[bb3_pkg::CH_GREEN][7:0];
			res.blue = avg[bb3_pkg::CH_BLUE][7:0];
			res.frame_end = (out_col + 1 >= w) && (out_row + 1 >= h);
			expected_pixels.push_back(res);
			step_pos(out_row, out_col, w, h);
		endfunction

		// Notes an accepted request; returns whether the core had anything to do with it.
		function bit note_request(logic mode, bb3_pkg::pix_t px);
			int unsigned w, h;
			bit          live;
			w = (width_reg == 0) ? 1 :
				(width_reg > bb3_pkg::MAX_WIDTH) ? bb3_pkg::MAX_WIDTH : width_reg;
			h = (height_reg == 0) ? 1 : height_reg;
			live = (mode == bb3_pkg::MODE_PIXEL) || (backlog != 0);
			if (mode == bb3_pkg::MODE_PIXEL) begin
				push_into_window(px, w, h);
				backlog++;
				if (backlog > w + 1) begin
					blur_next_output(w, h);
					backlog--;
				end
			end else if (backlog != 0) begin
				// A drain pushes a black pixel and emits one pending output.
				push_into_window('0, w, h);
				blur_next_output(w, h);
				backlog--;
				if (backlog == 0) begin
					in_row = out_row;
					in_col = out_col;
				end
			end
			return live;
		endfunction

		function void check_result(blurred_t got);
			blurred_t want;
			bit       bad;
			if (expected_pixels.size() == 0) begin
				errors++;
				if (errors <= 20)
					$display("%0t: unexpected result r=%0d g=%0d b=%0d end=%0b", $time,
						got.red, got.green, got.blue, got.frame_end);
				return;
			end
			want = expected_pixels.pop_front();
			bad = (got.red !== want.red) || (got.green !== want.green) ||
				(got.blue !== want.blue) || (got.frame_end !== want.frame_end);
			if (bad) begin
				errors++;
				if (errors <= 20)
					$display("%0t: expected r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
						$time, want.red, want.green, want.blue, want.frame_end,
						got.red, got.green, got.blue, got.frame_end);
			end
		endfunction
	endclass

	localparam longint WATCHDOG_NS  = 4_000_000;
	localparam int     RANDOM_ITEMS = 930;
	// Widest frame of the random phases; the warm-up frame writes these columns.
	localparam int     FILL_WIDTH   = 64;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data;

	bb3_pix_if pix_ch ();
	bb3_res_if res_ch ();

	box_blur_3x3_edge_average_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixel    (pix_ch),
		.result   (res_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	blur_scoreboard board;
	int unsigned    live_count = 0;
	int unsigned    hold_request = 0;
	bit             src_steady = 1'b0;
	bit             sink_steady = 1'b0;

	// Clock generation.
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Mostly no gap or a short one, now and then a long one.
	function automatic int unsigned idle_length();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 96)
			return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	function automatic bb3_pkg::pix_t random_pixel();
		bb3_pkg::pix_t px;
		case ($urandom_range(0, 15))
			0: px = '0;
			1: px = '1;
			default: px = bb3_pkg::pix_t'($urandom);
		endcase
		return px;
	endfunction

	// Offers one request until it is accepted, then may idle for a while.
	task automatic send_request(input logic mode, input bb3_pkg::pix_t px);
		int unsigned gap;
		bit          pause;
		pix_ch.valid <= 1'b1;
		pix_ch.mode <= mode;
		pix_ch.red_in <= px[bb3_pkg::CH_RED];
		pix_ch.green_in <= px[bb3_pkg::CH_GREEN];
		pix_ch.blue_in <= px[bb3_pkg::CH_BLUE];
		do @(posedge clk); while (pix_ch.ready !== 1'b1);
		if (board.note_request(mode, px))
			live_count++;
		gap = src_steady ? 0 : idle_length();
		pause = !src_steady && ($urandom_range(0, 199) == 0);
		if (gap != 0 || pause) begin
			pix_ch.valid <= 1'b0;
			do @(posedge clk); while (pause && board.expected_pixels.size() != 0);
			repeat (gap) @(posedge clk);
		end
	endtask

	// Waits until every predicted pixel has arrived and the core has gone quiet.
	task automatic settle();
		if (pix_ch.valid === 1'b1)
			pix_ch.valid <= 1'b0;
		while (board.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic load_size(input logic [bb3_pkg::CFG_DATA_W-1:0] width_data,
			input logic [bb3_pkg::CFG_DATA_W-1:0] height_data);
		cfg_we <= 1'b1;
		cfg_idx <= bb3_pkg::REG_IMAGE_WIDTH;
		cfg_data <= width_data;
		@(posedge clk);
		board.write_reg(bb3_pkg::REG_IMAGE_WIDTH, width_data);
		cfg_idx <= bb3_pkg::REG_IMAGE_HEIGHT;
		cfg_data <= height_data;
		@(posedge clk);
		board.write_reg(bb3_pkg::REG_IMAGE_HEIGHT, height_data);
		cfg_we <= 1'b0;
	endtask

	// Result side: checks accepted pixels and stalls at random or on a hold request.
	initial begin : result_sink
		int unsigned stall_left;
		blurred_t    got;
		stall_left = 0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				got = {res_ch.red_out, res_ch.green_out, res_ch.blue_out, res_ch.frame_end};
				board.check_result(got);
			end
			if (hold_request != 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left != 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				if (!sink_steady)
					stall_left = idle_length();
			end
		end
	end

	// Ends a run that hangs.
	initial begin : watchdog
		#(WATCHDOG_NS);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		int unsigned w, h, n, r, c, kind, phase, shape;
		board = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= bb3_pkg::REG_IMAGE_WIDTH;
		cfg_data <= '0;
		pix_ch.valid <= 1'b0;
		pix_ch.mode <= bb3_pkg::MODE_PIXEL;
		pix_ch.red_in <= '0;
		pix_ch.green_in <= '0;
		pix_ch.blue_in <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two full rows at the widest frame used later write every line store
		// entry that any later frame reads.
		load_size(16'(FILL_WIDTH), 16'd2);
		repeat (2 * FILL_WIDTH) send_request(bb3_pkg::MODE_PIXEL, random_pixel());
		while (board.backlog != 0)
			send_request(bb3_pkg::MODE_DRAIN, random_pixel());
		settle();

		// A drain with nothing pending yields no result.
		send_request(bb3_pkg::MODE_DRAIN, random_pixel());
		settle();

		// Width and height of zero are taken as a single-pixel frame.
		load_size('0, '0);
		send_request(bb3_pkg::MODE_PIXEL, {8'hFF, 8'h00, 8'hFF});
		send_request(bb3_pkg::MODE_PIXEL, {8'h00, 8'hFF, 8'h00});
		send_request(bb3_pkg::MODE_PIXEL, '1);
		repeat (3) send_request(bb3_pkg::MODE_DRAIN, '0);
		settle();

		// A width above the line stores is clamped; drains empty the pipeline mid-row.
		load_size(16'h07FF, 16'd1);
		send_request(bb3_pkg::MODE_PIXEL, '1);
		send_request(bb3_pkg::MODE_PIXEL, '0);
		send_request(bb3_pkg::MODE_PIXEL, '1);
		repeat (3) send_request(bb3_pkg::MODE_DRAIN, '1);
		settle();

		// Tallest frame, then a narrower one that leaves the input position beyond
		// the frame and more pixels pending than one row plus one.
		load_size(16'd5, 16'hFFFF);
		repeat (4) send_request(bb3_pkg::MODE_PIXEL, random_pixel());
		settle();
		load_size(16'd2, 16'hFFFF);
		repeat (2) send_request(bb3_pkg::MODE_PIXEL, random_pixel());
		while (board.backlog != 0)
			send_request(bb3_pkg::MODE_DRAIN, random_pixel());
		settle();

		// Random phases: mostly whole frames, some noise and unflushed tails.
		live_count = 0;
		phase = 0;
		while (live_count < RANDOM_ITEMS || phase < 3) begin
			phase++;
			// The hold-off phase uses a frame tall enough to produce results from pixels.
			shape = (phase == 3) ? 9 : $urandom_range(0, 9);
			case (shape)
				0: begin
					w = $urandom_range(17, FILL_WIDTH);
					h = $urandom_range(1, 3);
				end
				1: begin
					w = 1;
					h = $urandom_range(1, 12);
				end
				2: begin
					w = $urandom_range(2, 12);
					h = 1;
				end
				default: begin
					w = $urandom_range(2, 12);
					h = $urandom_range(2, 8);
				end
			endcase
			load_size({5'($urandom), 11'(w)}, 16'(h));
			src_steady = ($urandom_range(0, 4) == 0);
			sink_steady = ($urandom_range(0, 4) == 0);
			// One long hold-off on the result side while pixels keep coming.
			if (phase == 3) begin
				src_steady = 1'b1;
				hold_request = 400;
			end
			kind = $urandom_range(0, 9);
			if (kind < 7 || phase == 3) begin
				// Finish the current frame first so that the whole frames line up.
				r = board.in_row;
				c = board.in_col;
				n = 0;
				while (r != 0 || c != 0) begin
					c++;
					if (c >= w) begin
						c = 0;
						r++;
						if (r >= h)
							r = 0;
					end
					n++;
				end
				n += $urandom_range(1, 2) * w * h;
				repeat (n) send_request(bb3_pkg::MODE_PIXEL, random_pixel());
				// Usually flushed by drains; otherwise the next phase pushes it out.
				if ($urandom_range(0, 3) != 0)
					while (board.backlog != 0)
						send_request(bb3_pkg::MODE_DRAIN, random_pixel());
			end else begin
				repeat ($urandom_range(1, 30))
					send_request(($urandom_range(0, 3) == 0) ?
						bb3_pkg::MODE_DRAIN : bb3_pkg::MODE_PIXEL, random_pixel());
			end
			settle();
		end

		if (board.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
